>>> hw/rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, token codes and character-class helpers for the source
// token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

	// scan modes
	typedef enum logic [3:0] {
		M_IDLE, M_NUM, M_NUMDOT, M_FRAC, M_IDENT,
		M_ROPEN, M_RESC, M_RCLOSE, M_RMULTI
	} mode_t;

	// token kinds
	localparam logic [4:0] TK_END     = 5'd0;
	localparam logic [4:0] TK_NEWLINE = 5'd1;
	localparam logic [4:0] TK_INT     = 5'd2;
	localparam logic [4:0] TK_FLOAT   = 5'd3;
	localparam logic [4:0] TK_RUNE    = 5'd4;
	localparam logic [4:0] TK_IDENT   = 5'd5;
	localparam logic [4:0] TK_TRUE    = 5'd6;
	localparam logic [4:0] TK_FALSE   = 5'd7;
	localparam logic [4:0] TK_IF      = 5'd8;
	localparam logic [4:0] TK_INT8    = 5'd9;
	localparam logic [4:0] TK_INT16   = 5'd10;
	localparam logic [4:0] TK_INT32   = 5'd11;
	localparam logic [4:0] TK_INT64   = 5'd12;
	localparam logic [4:0] TK_FLT8    = 5'd13;
	localparam logic [4:0] TK_FLT16   = 5'd14;
	localparam logic [4:0] TK_FLT32   = 5'd15;
	localparam logic [4:0] TK_FLT64   = 5'd16;
	localparam logic [4:0] TK_PLUS    = 5'd17;
	localparam logic [4:0] TK_MINUS   = 5'd18;
	localparam logic [4:0] TK_STAR    = 5'd19;
	localparam logic [4:0] TK_BSLASH  = 5'd20;
	localparam logic [4:0] TK_PCT     = 5'd21;
	localparam logic [4:0] TK_LBRACE  = 5'd22;
	localparam logic [4:0] TK_RBRACE  = 5'd23;
	localparam logic [4:0] TK_EQ      = 5'd24;
	localparam logic [4:0] TK_ERROR   = 5'd25;
	localparam logic [4:0] TK_FATAL   = 5'd26;

	// error kinds
	localparam logic [2:0] ER_NONE    = 3'd0;
	localparam logic [2:0] ER_BADCH   = 3'd1;
	localparam logic [2:0] ER_UNTERM  = 3'd2;
	localparam logic [2:0] ER_NLRUNE  = 3'd3;
	localparam logic [2:0] ER_BADESC  = 3'd4;
	localparam logic [2:0] ER_MULTI   = 3'd5;
	localparam logic [2:0] ER_MALFORM = 3'd6;

	localparam int FW = 24;	// width of offset fields on the result port

	typedef struct packed {
		logic [4:0]    kind;
		logic [2:0]    err;
		logic [FW-1:0] start;
		logic [FW-1:0] len;
		logic [FW-1:0] line;
		logic [FW-1:0] line_base;
	} tok_t;

	// keyword automaton: final state to token kind
	localparam logic [4:0] KW_KIND [32] = '{
		5'd5, 5'd5, 5'd5, 5'd5, 5'd6, 5'd5, 5'd5, 5'd5,
		5'd5, 5'd7, 5'd5, 5'd5, 5'd5, 5'd5, 5'd13, 5'd5,
		5'd14, 5'd5, 5'd15, 5'd5, 5'd16, 5'd5, 5'd8, 5'd5,
		5'd5, 5'd9, 5'd5, 5'd10, 5'd5, 5'd11, 5'd5, 5'd12
	};

	function automatic logic is_dig(input logic [20:0] c);
		return (c >= 21'h30) && (c <= 21'h39);
	endfunction

	function automatic logic is_alp(input logic [20:0] c);
		return ((c >= 21'h61) && (c <= 21'h7a)) || ((c >= 21'h41) && (c <= 21'h5a));
	endfunction

	// keyword automaton step
	function automatic logic [4:0] kw_next(input logic [4:0] st, input logic [20:0] c);
		logic [4:0] nx;
		nx = 5'd0;
		case (st)
			5'd1:  if (c == 21'h72) nx = 5'd2;
			5'd2:  if (c == 21'h75) nx = 5'd3;
			5'd3:  if (c == 21'h65) nx = 5'd4;
			5'd5: begin
				if (c == 21'h61) nx = 5'd6;
				else if (c == 21'h6c) nx = 5'd10;
			end
			5'd6:  if (c == 21'h6c) nx = 5'd7;
			5'd7:  if (c == 21'h73) nx = 5'd8;
			5'd8:  if (c == 21'h65) nx = 5'd9;
			5'd10: if (c == 21'h6f) nx = 5'd11;
			5'd11: if (c == 21'h61) nx = 5'd12;
			5'd12: if (c == 21'h74) nx = 5'd13;
			5'd13: begin
				if (c == 21'h38) nx = 5'd14;
				else if (c == 21'h31) nx = 5'd15;
				else if (c == 21'h33) nx = 5'd17;
				else if (c == 21'h36) nx = 5'd19;
			end
			5'd15: if (c == 21'h36) nx = 5'd16;
			5'd17: if (c == 21'h32) nx = 5'd18;
			5'd19: if (c == 21'h34) nx = 5'd20;
			5'd21: begin
				if (c == 21'h66) nx = 5'd22;
				else if (c == 21'h6e) nx = 5'd23;
			end
			5'd23: if (c == 21'h74) nx = 5'd24;
			5'd24: begin
				if (c == 21'h38) nx = 5'd25;
				else if (c == 21'h31) nx = 5'd26;
				else if (c == 21'h33) nx = 5'd28;
				else if (c == 21'h36) nx = 5'd30;
			end
			5'd26: if (c == 21'h36) nx = 5'd27;
			5'd28: if (c == 21'h32) nx = 5'd29;
			5'd30: if (c == 21'h34) nx = 5'd31;
			default: nx = 5'd0;
		endcase
		return nx;
	endfunction

endpackage

>>> hw/rtl/sts_step.sv
// ----------------------------------------------------------------------------
// sts_step
// Combinational scan of one character: next scanner state and up to three
// tokens completed by it.
// ----------------------------------------------------------------------------
module sts_step #(
	parameter int W = 24
) (
	input  logic [20:0]          code_point,
	input  logic [2:0]           byte_count,
	input  logic                 malformed,
	input  sts_pkg::mode_t       mode_q,
	input  logic [4:0]           kw_q,
	input  logic [W-1:0]         pos_q,
	input  logic [W-1:0]         tb_q,
	input  logic [W-1:0]         line_q,
	input  logic [W-1:0]         lb_q,
	input  logic [W-1:0]         rn_q,
	input  logic                 fatal_q,
	output sts_pkg::mode_t       mode_d,
	output logic [4:0]           kw_d,
	output logic [W-1:0]         pos_d,
	output logic [W-1:0]         tb_d,
	output logic [W-1:0]         line_d,
	output logic [W-1:0]         lb_d,
	output logic [W-1:0]         rn_d,
	output logic                 fatal_d,
	output sts_pkg::tok_t        res [3],
	output logic [1:0]           res_cnt
);

	function automatic logic [W-1:0] sat(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[W] ? {W{1'b1}} : s[W-1:0];
	endfunction

	function automatic sts_pkg::tok_t mk(input logic [4:0] k, input logic [2:0] e,
			input logic [W-1:0] st, input logic [W-1:0] ln,
			input logic [W-1:0] li, input logic [W-1:0] lbg, input logic f);
		sts_pkg::tok_t t;
		t.kind      = f ? sts_pkg::TK_FATAL : k;
		t.err       = f ? sts_pkg::ER_MALFORM : e;
		t.start     = sts_pkg::FW'(st);
		t.len       = sts_pkg::FW'(ln);
		t.line      = sts_pkg::FW'(li);
		t.line_base = sts_pkg::FW'(lbg);
		return t;
	endfunction

	logic [20:0]    c;
	logic [W-1:0]   bc;
	logic [W-1:0]   one;
	logic           f;
	logic           idle;
	sts_pkg::mode_t m;
	logic [4:0]     kw;
	logic [W-1:0]   pos, tb, line, lb, rn;
	logic [1:0]     n;

	always_comb begin
		c    = malformed ? 21'd0 : code_point;
		f    = fatal_q | malformed;
		bc   = W'(byte_count);
		one  = W'(1);
		m    = mode_q;
		kw   = kw_q;
		pos  = pos_q;
		tb   = tb_q;
		line = line_q;
		lb   = lb_q;
		rn   = rn_q;
		n    = 2'd0;
		idle = 1'b0;
		for (int i = 0; i < 3; i++) res[i] = '0;

		// mode-specific handling
		case (mode_q)
			sts_pkg::M_NUM: begin
				if (sts_pkg::is_dig(c)) pos = sat(pos, bc);
				else if (c == 21'h2e) m = sts_pkg::M_NUMDOT;
				else begin
					res[n] = mk(sts_pkg::TK_INT, sts_pkg::ER_NONE, tb, pos - tb, line, lb, f);
					n = n + 2'd1;
					idle = 1'b1;
				end
			end
			sts_pkg::M_NUMDOT: begin
				if (sts_pkg::is_dig(c)) begin
					pos = sat(sat(pos, one), bc);
					m = sts_pkg::M_FRAC;
				end else begin
					res[n] = mk(sts_pkg::TK_INT, sts_pkg::ER_NONE, tb, pos - tb, line, lb, f);
					n = n + 2'd1;
					res[n] = mk(sts_pkg::TK_ERROR, sts_pkg::ER_BADCH, pos, one, line, lb, f);
					n = n + 2'd1;
					pos = sat(pos, one);
					idle = 1'b1;
				end
			end
			sts_pkg::M_FRAC: begin
				if (sts_pkg::is_dig(c)) pos = sat(pos, bc);
				else begin
					res[n] = mk(sts_pkg::TK_FLOAT, sts_pkg::ER_NONE, tb, pos - tb, line, lb, f);
					n = n + 2'd1;
					idle = 1'b1;
				end
			end
			sts_pkg::M_IDENT: begin
				if (sts_pkg::is_alp(c) || sts_pkg::is_dig(c) || c == 21'h5f) begin
					pos = sat(pos, bc);
					kw = sts_pkg::kw_next(kw, c);
				end else begin
					res[n] = mk(sts_pkg::KW_KIND[kw], sts_pkg::ER_NONE, tb, pos - tb,
						line, lb, f);
					n = n + 2'd1;
					kw = 5'd0;
					idle = 1'b1;
				end
			end
			sts_pkg::M_ROPEN: begin
				if (c == 21'd0) begin
					res[n] = mk(sts_pkg::TK_ERROR, sts_pkg::ER_UNTERM, tb, pos - tb,
						line, lb, f);
					n = n + 2'd1;
					idle = 1'b1;
				end else begin
					pos = sat(pos, bc);
					if (c == 21'h5c) m = sts_pkg::M_RESC;
					else if (c == 21'h0a) begin
						res[n] = mk(sts_pkg::TK_ERROR, sts_pkg::ER_NLRUNE, tb, pos - tb,
							line, lb, f);
						n = n + 2'd1;
						m = sts_pkg::M_IDLE;
					end else m = sts_pkg::M_RCLOSE;
				end
			end
			sts_pkg::M_RESC: begin
				if (c == 21'h30 || c == 21'h6e || c == 21'h74 || c == 21'h72 ||
						c == 21'h2f) begin
					pos = sat(pos, bc);
					m = sts_pkg::M_RCLOSE;
				end else begin
					res[n] = mk(sts_pkg::TK_ERROR, sts_pkg::ER_BADESC, tb, pos - tb,
						line, lb, f);
					n = n + 2'd1;
					idle = 1'b1;
				end
			end
			sts_pkg::M_RCLOSE: begin
				if (c == 21'h27) begin
					pos = sat(pos, bc);
					res[n] = mk(sts_pkg::TK_RUNE, sts_pkg::ER_NONE, tb, pos - tb, line, lb, f);
					n = n + 2'd1;
					m = sts_pkg::M_IDLE;
				end else if (c == 21'd0) begin
					// multi-character rune cut by end: no newlines counted
					res[n] = mk(sts_pkg::TK_ERROR, sts_pkg::ER_MULTI, tb, pos - tb,
						line, lb, f);
					n = n + 2'd1;
					rn = '0;
					idle = 1'b1;
				end else begin
					pos = sat(pos, bc);
					rn = (c == 21'h0a) ? one : '0;
					m = sts_pkg::M_RMULTI;
				end
			end
			sts_pkg::M_RMULTI: begin
				if (c == 21'd0 || c == 21'h27) begin
					if (c != 21'd0) pos = sat(pos, bc);
					res[n] = mk(sts_pkg::TK_ERROR, sts_pkg::ER_MULTI, tb, pos - tb,
						line, lb, f);
					n = n + 2'd1;
					line = sat(line, rn);
					rn = '0;
					m = sts_pkg::M_IDLE;
					idle = (c == 21'd0);
				end else begin
					pos = sat(pos, bc);
					if (c == 21'h0a) rn = sat(rn, one);
				end
			end
			default: idle = 1'b1;
		endcase

		// scan from between tokens
		if (idle) begin
			m = sts_pkg::M_IDLE;
			if (c == 21'd0) begin
				tb = pos;
				res[n] = mk(sts_pkg::TK_END, sts_pkg::ER_NONE, pos, '0, line, lb, f);
				n = n + 2'd1;
			end else if (c == 21'h20 || c == 21'h09) begin
				pos = sat(pos, bc);
			end else begin
				tb = pos;
				pos = sat(pos, bc);
				if (sts_pkg::is_dig(c)) m = sts_pkg::M_NUM;
				else if (sts_pkg::is_alp(c)) begin
					m = sts_pkg::M_IDENT;
					kw = (c == 21'h74) ? 5'd1 : (c == 21'h66) ? 5'd5 :
						(c == 21'h69) ? 5'd21 : 5'd0;
				end else begin
					case (c)
						21'h2b: begin res[n] = mk(sts_pkg::TK_PLUS, sts_pkg::ER_NONE,
							tb, pos - tb, line, lb, f); n = n + 2'd1; end
						21'h2d: begin res[n] = mk(sts_pkg::TK_MINUS, sts_pkg::ER_NONE,
							tb, pos - tb, line, lb, f); n = n + 2'd1; end
						21'h2a: begin res[n] = mk(sts_pkg::TK_STAR, sts_pkg::ER_NONE,
							tb, pos - tb, line, lb, f); n = n + 2'd1; end
						21'h5c: begin res[n] = mk(sts_pkg::TK_BSLASH, sts_pkg::ER_NONE,
							tb, pos - tb, line, lb, f); n = n + 2'd1; end
						21'h25: begin res[n] = mk(sts_pkg::TK_PCT, sts_pkg::ER_NONE,
							tb, pos - tb, line, lb, f); n = n + 2'd1; end
						21'h7b: begin res[n] = mk(sts_pkg::TK_LBRACE, sts_pkg::ER_NONE,
							tb, pos - tb, line, lb, f); n = n + 2'd1; end
						21'h7d: begin res[n] = mk(sts_pkg::TK_RBRACE, sts_pkg::ER_NONE,
							tb, pos - tb, line, lb, f); n = n + 2'd1; end
						21'h3d: begin res[n] = mk(sts_pkg::TK_EQ, sts_pkg::ER_NONE,
							tb, pos - tb, line, lb, f); n = n + 2'd1; end
						21'h27: m = sts_pkg::M_ROPEN;
						21'h0a: begin
							res[n] = mk(sts_pkg::TK_NEWLINE, sts_pkg::ER_NONE,
								tb, pos - tb, line, lb, f);
							n = n + 2'd1;
							line = sat(line, one);
							lb = pos;
						end
						default: begin res[n] = mk(sts_pkg::TK_ERROR, sts_pkg::ER_BADCH,
							tb, pos - tb, line, lb, f); n = n + 2'd1; end
					endcase
				end
			end
		end

		mode_d  = m;
		kw_d    = kw;
		pos_d   = pos;
		tb_d    = tb;
		line_d  = line;
		lb_d    = lb;
		rn_d    = rn;
		fatal_d = f;
		res_cnt = n;
	end

endmodule

>>> hw/rtl/sts_outq.sv
// ----------------------------------------------------------------------------
// sts_outq
// Result register holding the tokens of one character and handing them out
// one transaction per cycle while tok_stall is low.
// ----------------------------------------------------------------------------
module sts_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  sts_pkg::tok_t res [3],
	input  logic [1:0]    res_cnt,
	output logic          busy,
	output logic          tok_valid,
	input  logic          tok_stall,
	output sts_pkg::tok_t tok,
	output logic          last
);

	sts_pkg::tok_t buf_q [3];
	logic [1:0]    cnt_q;
	logic [1:0]    idx_q;
	logic          take;

	assign tok_valid = (cnt_q != 2'd0);
	assign tok       = buf_q[idx_q];
	assign last      = (idx_q == cnt_q - 2'd1);
	assign take      = tok_valid & ~tok_stall;
	// new character may enter once the final token leaves this cycle
	assign busy      = tok_valid & ~(last & ~tok_stall);

	// token payload
	always_ff @(posedge clk) begin
		if (load) buf_q <= res;
	end

	// count and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res_cnt;
			idx_q <= 2'd0;
		end else if (take) begin
			if (last) cnt_q <= 2'd0;
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

>>> hw/rtl/source_token_scanner_top.sv
// ----------------------------------------------------------------------------
// source_token_scanner_top
// Scans decoded characters into tokens with offsets and line positions.
// ----------------------------------------------------------------------------
// Usage: characters arrive on the src channel (code_point, byte_count,
// malformed) under src_valid/src_stall; tokens leave on the tok channel
// under tok_valid/tok_stall, one token per transaction, last_of_run set on
// the final token caused by a character. A character is scanned in the
// cycle it is accepted and its tokens are registered, so the first token
// shows in the cycle after acceptance. A character that yields no token or
// one token leaves src_stall low while tok_stall is low; one that yields more
// holds src_stall until its final token leaves, as the single result register
// drains one token per cycle. While tok_stall is high the current token holds and
// src_stall rises once the result register cannot drain. Reset clears
// position and line counters (line one), the scan mode and the fatal flag;
// a malformed character turns every later token fatal until reset.
// ----------------------------------------------------------------------------
module source_token_scanner_top #(
	parameter int OFFSET_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [20:0] code_point,
	input  logic [2:0]  byte_count,
	input  logic        malformed,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [4:0]  token_kind,
	output logic [2:0]  error_kind,
	output logic [23:0] start_offset,
	output logic [23:0] token_length,
	output logic [23:0] line_number,
	output logic [23:0] line_offset,
	output logic        last_of_run
);

	localparam int W = OFFSET_BITS;

	sts_pkg::mode_t mode_q, mode_d;
	logic [4:0]     kw_q, kw_d;
	logic [W-1:0]   pos_q, pos_d, tb_q, tb_d, line_q, line_d;
	logic [W-1:0]   lb_q, lb_d, rn_q, rn_d;
	logic           fatal_q, fatal_d;
	sts_pkg::tok_t  res [3];
	logic [1:0]     res_cnt;
	logic           busy, accept;
	sts_pkg::tok_t  tok;

	assign src_stall = busy;
	assign accept    = src_valid & ~busy;

	sts_step #(.W(W)) u_step (
		.code_point, .byte_count, .malformed,
		.mode_q, .kw_q, .pos_q, .tb_q, .line_q, .lb_q, .rn_q, .fatal_q,
		.mode_d, .kw_d, .pos_d, .tb_d, .line_d, .lb_d, .rn_d, .fatal_d,
		.res, .res_cnt
	);

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sts_pkg::M_IDLE;
			kw_q    <= 5'd0;
			pos_q   <= '0;
			tb_q    <= '0;
			line_q  <= W'(1);
			lb_q    <= '0;
			rn_q    <= '0;
			fatal_q <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			kw_q    <= kw_d;
			pos_q   <= pos_d;
			tb_q    <= tb_d;
			line_q  <= line_d;
			lb_q    <= lb_d;
			rn_q    <= rn_d;
			fatal_q <= fatal_d;
		end
	end

	sts_outq u_outq (
		.clk, .arst_n, .load(accept), .res, .res_cnt, .busy,
		.tok_valid, .tok_stall, .tok, .last(last_of_run)
	);

	assign token_kind   = tok.kind;
	assign error_kind   = tok.err;
	assign start_offset = tok.start;
	assign token_length = tok.len;
	assign line_number  = tok.line;
	assign line_offset  = tok.line_base;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the source token scanner. Directed text covers
// every non-fatal token kind, keyword, operator and rune error; random text is
// mostly well-formed tokens with noise and odd byte counts mixed in. A
// malformed character near the end turns the rest fatal. Both channels
// idle at random, and every token is checked against an in-bench scanner.
// ----------------------------------------------------------------------------

typedef struct {
	sts_pkg::tok_t tok;
	bit            last;
} tok_exp_t;

// Scanner predictor and store of expected tokens
class token_scoreboard;
	sts_pkg::mode_t mode;
	logic [4:0]     kw_state;
	logic [23:0]    pos, tok_begin, line, line_begin, rune_nl;
	bit             fatal;
	tok_exp_t       pending[$];
	tok_exp_t       step_toks[$];
	int             fails, n_chars, n_toks;

	function new();
		mode = sts_pkg::M_IDLE;
		kw_state = 0;
		pos = 0;
		tok_begin = 0;
		line = 1;
		line_begin = 0;
		rune_nl = 0;
		fatal = 0;
	endfunction

	function logic [23:0] sat(logic [23:0] a, logic [23:0] b);
		logic [24:0] r;
		r = {1'b0, a} + {1'b0, b};
		return r[24] ? 24'hFFFFFF : r[23:0];
	endfunction

	function bit digit(int c);
		return c >= "0" && c <= "9";
	endfunction

	function bit letter(int c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// keyword prefix tracker
	function logic [4:0] kw_step(logic [4:0] st, int c);
		case (st)
			1:  return c == "r" ? 2 : 0;
			2:  return c == "u" ? 3 : 0;
			3:  return c == "e" ? 4 : 0;
			5:  return c == "a" ? 6 : (c == "l" ? 10 : 0);
			6:  return c == "l" ? 7 : 0;
			7:  return c == "s" ? 8 : 0;
			8:  return c == "e" ? 9 : 0;
			10: return c == "o" ? 11 : 0;
			11: return c == "a" ? 12 : 0;
			12: return c == "t" ? 13 : 0;
			13, 24: begin
				if (c == "8") return st + 1;
				if (c == "1") return st + 2;
				if (c == "3") return st + 4;
				if (c == "6") return st + 6;
				return 0;
			end
			15, 26: return c == "6" ? st + 1 : 0;
			17, 28: return c == "2" ? st + 1 : 0;
			19, 30: return c == "4" ? st + 1 : 0;
			21: return c == "f" ? 22 : (c == "n" ? 23 : 0);
			23: return c == "t" ? 24 : 0;
			default: return 0;
		endcase
	endfunction

	function logic [4:0] kw_token(logic [4:0] st);
		case (st)
			4:  return sts_pkg::TK_TRUE;
			9:  return sts_pkg::TK_FALSE;
			22: return sts_pkg::TK_IF;
			25: return sts_pkg::TK_INT8;
			27: return sts_pkg::TK_INT16;
			29: return sts_pkg::TK_INT32;
			31: return sts_pkg::TK_INT64;
			14: return sts_pkg::TK_FLT8;
			16: return sts_pkg::TK_FLT16;
			18: return sts_pkg::TK_FLT32;
			20: return sts_pkg::TK_FLT64;
			default: return sts_pkg::TK_IDENT;
		endcase
	endfunction

	function void emit(logic [4:0] kind, logic [2:0] err, logic [23:0] st,
			logic [23:0] len);
		tok_exp_t e;
		if (step_toks.size() >= 3) return;
		if (fatal) begin
			kind = sts_pkg::TK_FATAL;
			err = sts_pkg::ER_MALFORM;
		end
		e.tok = '{kind, err, st, len, line, line_begin};
		e.last = 0;
		step_toks.push_back(e);
	endfunction

	function void emit_tok(logic [4:0] kind, logic [2:0] err);
		emit(kind, err, tok_begin, pos - tok_begin);
	endfunction

	function void scan_idle(int c, logic [23:0] bc);
		mode = sts_pkg::M_IDLE;
		if (c == 0) begin
			tok_begin = pos;
			emit_tok(sts_pkg::TK_END, sts_pkg::ER_NONE);
			return;
		end
		if (c == " " || c == "\t") begin
			pos = sat(pos, bc);
			return;
		end
		tok_begin = pos;
		pos = sat(pos, bc);
		if (digit(c)) begin
			mode = sts_pkg::M_NUM;
			return;
		end
		if (letter(c)) begin
			mode = sts_pkg::M_IDENT;
			kw_state = c == "t" ? 1 : (c == "f" ? 5 : (c == "i" ? 21 : 0));
			return;
		end
		case (c)
			"+": emit_tok(sts_pkg::TK_PLUS, sts_pkg::ER_NONE);
			"-": emit_tok(sts_pkg::TK_MINUS, sts_pkg::ER_NONE);
			"*": emit_tok(sts_pkg::TK_STAR, sts_pkg::ER_NONE);
			"\\": emit_tok(sts_pkg::TK_BSLASH, sts_pkg::ER_NONE);
			"%": emit_tok(sts_pkg::TK_PCT, sts_pkg::ER_NONE);
			"{": emit_tok(sts_pkg::TK_LBRACE, sts_pkg::ER_NONE);
			"}": emit_tok(sts_pkg::TK_RBRACE, sts_pkg::ER_NONE);
			"=": emit_tok(sts_pkg::TK_EQ, sts_pkg::ER_NONE);
			"'": mode = sts_pkg::M_ROPEN;
			"\n": begin
				emit_tok(sts_pkg::TK_NEWLINE, sts_pkg::ER_NONE);
				line = sat(line, 1);
				line_begin = pos;
			end
			default: emit_tok(sts_pkg::TK_ERROR, sts_pkg::ER_BADCH);
		endcase
	endfunction

	// close a multi-character rune; its newlines count only afterwards
	function void close_multi();
		emit_tok(sts_pkg::TK_ERROR, sts_pkg::ER_MULTI);
		line = sat(line, rune_nl);
		rune_nl = 0;
		mode = sts_pkg::M_IDLE;
	endfunction

	function void scan(int c, logic [23:0] bc);
		case (mode)
			sts_pkg::M_NUM: begin
				if (digit(c)) pos = sat(pos, bc);
				else if (c == ".") mode = sts_pkg::M_NUMDOT;
				else begin
					emit_tok(sts_pkg::TK_INT, sts_pkg::ER_NONE);
					scan_idle(c, bc);
				end
			end
			sts_pkg::M_NUMDOT: begin
				if (digit(c)) begin
					pos = sat(sat(pos, 1), bc);
					mode = sts_pkg::M_FRAC;
				end else begin
					emit_tok(sts_pkg::TK_INT, sts_pkg::ER_NONE);
					emit(sts_pkg::TK_ERROR, sts_pkg::ER_BADCH, pos, 1);
					pos = sat(pos, 1);
					scan_idle(c, bc);
				end
			end
			sts_pkg::M_FRAC: begin
				if (digit(c)) pos = sat(pos, bc);
				else begin
					emit_tok(sts_pkg::TK_FLOAT, sts_pkg::ER_NONE);
					scan_idle(c, bc);
				end
			end
			sts_pkg::M_IDENT: begin
				if (letter(c) || digit(c) || c == "_") begin
					pos = sat(pos, bc);
					kw_state = kw_step(kw_state, c);
				end else begin
					emit_tok(kw_token(kw_state), sts_pkg::ER_NONE);
					kw_state = 0;
					scan_idle(c, bc);
				end
			end
			sts_pkg::M_ROPEN: begin
				if (c == 0) begin
					emit_tok(sts_pkg::TK_ERROR, sts_pkg::ER_UNTERM);
					scan_idle(c, bc);
				end else begin
					pos = sat(pos, bc);
					if (c == "\\") mode = sts_pkg::M_RESC;
					else if (c == "\n") begin
						emit_tok(sts_pkg::TK_ERROR, sts_pkg::ER_NLRUNE);
						mode = sts_pkg::M_IDLE;
					end else mode = sts_pkg::M_RCLOSE;
				end
			end
			sts_pkg::M_RESC: begin
				if (c == "0" || c == "n" || c == "t" || c == "r" || c == "/") begin
					pos = sat(pos, bc);
					mode = sts_pkg::M_RCLOSE;
				end else begin
					emit_tok(sts_pkg::TK_ERROR, sts_pkg::ER_BADESC);
					scan_idle(c, bc);
				end
			end
			sts_pkg::M_RCLOSE: begin
				if (c == "'") begin
					pos = sat(pos, bc);
					emit_tok(sts_pkg::TK_RUNE, sts_pkg::ER_NONE);
					mode = sts_pkg::M_IDLE;
				end else begin
					rune_nl = 0;
					if (c == 0) begin
						close_multi();
						scan_idle(c, bc);
					end else begin
						pos = sat(pos, bc);
						if (c == "\n") rune_nl = 1;
						mode = sts_pkg::M_RMULTI;
					end
				end
			end
			sts_pkg::M_RMULTI: begin
				if (c == 0) begin
					close_multi();
					scan_idle(c, bc);
				end else begin
					pos = sat(pos, bc);
					if (c == "'") close_multi();
					else if (c == "\n") rune_nl = sat(rune_nl, 1);
				end
			end
			default: scan_idle(c, bc);
		endcase
	endfunction

	function void note_char(logic [20:0] cp, logic [2:0] bc, logic mal);
		int c;
		c = cp;
		n_chars++;
		step_toks.delete();
		if (mal) begin
			fatal = 1;
			c = 0;
		end
		scan(c, {21'd0, bc});
		if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1;
		foreach (step_toks[i]) pending.push_back(step_toks[i]);
	endfunction

	function void check_token(sts_pkg::tok_t got, bit got_last);
		tok_exp_t e;
		n_toks++;
		if (pending.size() == 0) begin
			$error("token with nothing expected: kind %0d at offset %0d",
				got.kind, got.start);
			fails++;
			return;
		end
		e = pending.pop_front();
		if (got.kind !== e.tok.kind) begin
			$error("token_kind: expected %0d, actual %0d", e.tok.kind, got.kind);
			fails++;
		end
		if (got.err !== e.tok.err) begin
			$error("error_kind: expected %0d, actual %0d", e.tok.err, got.err);
			fails++;
		end
		if (got.start !== e.tok.start) begin
			$error("start_offset: expected %0d, actual %0d", e.tok.start, got.start);
			fails++;
		end
		if (got.len !== e.tok.len) begin
			$error("token_length: expected %0d, actual %0d", e.tok.len, got.len);
			fails++;
		end
		if (got.line !== e.tok.line) begin
			$error("line_number: expected %0d, actual %0d", e.tok.line, got.line);
			fails++;
		end
		if (got.line_base !== e.tok.line_base) begin
			$error("line_offset: expected %0d, actual %0d", e.tok.line_base,
				got.line_base);
			fails++;
		end
		if (got_last !== e.last) begin
			$error("last_of_run: expected %0d, actual %0d", e.last, got_last);
			fails++;
		end
	endfunction
endclass

module tb_top;
	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		logic [20:0] cp;
		logic [2:0]  bc;
		logic        mal;
	} char_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        src_valid = 0;
	logic        src_stall;
	logic [20:0] code_point = 0;
	logic [2:0]  byte_count = 1;
	logic        malformed = 0;
	logic        tok_valid;
	logic        tok_stall = 0;
	logic [4:0]  token_kind;
	logic [2:0]  error_kind;
	logic [23:0] start_offset, token_length, line_number, line_offset;
	logic        last_of_run;

	token_scoreboard sb = new();
	char_t           text[$];
	bit              calm = 0;
	int              idle_cycles = 0;

	source_token_scanner_top i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// monitor both channels
	always @(posedge clk) begin
		if (src_valid && !src_stall) sb.note_char(code_point, byte_count, malformed);
		if (tok_valid && !tok_stall)
			sb.check_token('{token_kind, error_kind, start_offset, token_length,
				line_number, line_offset}, last_of_run);
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (tok_valid && !tok_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 20);
	endfunction

	// token side back-pressure
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (calm) tok_stall <= 0;
			else begin
				if (hold == 0 && $urandom_range(0, 149) == 0) hold = $urandom_range(5, 25);
				if (hold > 0) begin
					tok_stall <= 1;
					hold--;
				end else tok_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	function void put(int cp, int bc = 1, bit mal = 0);
		char_t ch;
		ch.cp = cp;
		ch.bc = bc;
		ch.mal = mal;
		if (bc == 1 && $urandom_range(0, 19) == 0) ch.bc = $urandom_range(0, 7);
		text.push_back(ch);
	endfunction

	function void put_str(string s);
		foreach (s[i]) put(s[i]);
	endfunction

	function int any_letter();
		return $urandom_range(0, 1) ? $urandom_range("a", "z") : $urandom_range("A", "Z");
	endfunction

	// one random token of well-formed or broken text
	function void put_token();
		string kws[11] = '{"true", "false", "if", "int8", "int16", "int32", "int64",
			"float8", "float16", "float32", "float64"};
		string near[6] = '{"tru", "fals", "int6", "floatx", "if_2", "int128"};
		string ops = "+-*\\%{}=";
		string esc = "0ntr/q\\x";
		int n;
		case ($urandom_range(0, 15))
			0, 1: put_str(kws[$urandom_range(0, 10)]);
			2: put_str(near[$urandom_range(0, 5)]);
			3: begin
				put(any_letter());
				repeat ($urandom_range(0, 5))
					case ($urandom_range(0, 2))
						0: put(any_letter());
						1: put($urandom_range("0", "9"));
						default: put("_");
					endcase
			end
			4, 5: repeat ($urandom_range(1, 6)) put($urandom_range("0", "9"));
			6: begin
				repeat ($urandom_range(1, 3)) put($urandom_range("0", "9"));
				put(".");
				if ($urandom_range(0, 2) != 0)
					repeat ($urandom_range(1, 3)) put($urandom_range("0", "9"));
				else put(any_letter());
			end
			7: begin
				put("'");
				put($urandom_range(0, 3) == 0 ? $urandom_range(128, 1114111)
					: $urandom_range("a", "z"));
				put("'");
			end
			8: begin
				put("'");
				put("\\");
				put(esc[$urandom_range(0, 7)]);
				put("'");
			end
			9: begin
				put("'");
				n = $urandom_range(2, 5);
				repeat (n) put($urandom_range(0, 3) == 0 ? "\n" : any_letter());
				if ($urandom_range(0, 3) != 0) put("'");
				else put(0);
			end
			10: put_str("'\n");
			11: put(ops[$urandom_range(0, 7)]);
			12: put("\n");
			13: put(0);
			14: put($urandom_range(1, 1114111), $urandom_range(0, 7));
			default: put($urandom_range(128, 1114111), $urandom_range(2, 4));
		endcase
		case ($urandom_range(0, 5))
			0, 1: put(" ");
			2: put("\t");
			3: put("\n");
			default: ;
		endcase
	endfunction

	task automatic send_char(char_t ch);
		int g;
		g = gap_len();
		if (g > 0) begin
			src_valid <= 0;
			repeat (g) @(posedge clk);
		end
		src_valid <= 1;
		code_point <= ch.cp;
		byte_count <= ch.bc;
		malformed <= ch.mal;
		@(posedge clk);
		while (src_stall) @(posedge clk);
	endtask

	initial begin
		int n_directed;
		// directed text: keywords, numbers, operators and every rune case
		put_str("true false if int8 int16 int32 int64\n");
		put_str("float8 float16 float32 float64 ab_9 ");
		put_str("12.5 3.x 7 +-*\\%{}= ");
		put_str("'a' '\\n' '\\/' '\\q' '\n");
		put_str("'ab\ncd' '\\");
		put(0);
		put(21'h10FFFF, 4);
		put(21'h0FFFFF, 7);
		put("'");
		put(0);
		put(0, 0);
		n_directed = text.size();
		while (text.size() < n_directed + 290) put_token();
		// malformed input near the end: everything after turns fatal
		put_str("ab");
		put($urandom_range(0, 1114111), $urandom_range(0, 7), 1);
		put_str("12 x'");
		put(0);

		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (text[i]) begin
			calm = (i % 100) >= 75;
			send_char(text[i]);
		end
		src_valid <= 0;
		calm = 0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Scanned %0d characters (%0d directed), checked %0d tokens.",
			sb.n_chars, n_directed, sb.n_toks);
		$display("Covered keywords, numbers, operators, rune errors and fatal tail.");
		if (sb.fails == 0 && sb.pending.size() == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
